// ===== src/aspf_pkg.sv =====
package aspf_pkg;

  localparam int COORD_W        = 3;
  localparam int G_W            = 7;
  localparam int DIM_W          = 4;
  localparam int CFG_IDX_W      = 2;
  localparam int DEF_MAX_WIDTH  = 8;
  localparam int DEF_MAX_HEIGHT = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REG_HEIGHT = 2'd1;

  localparam logic [G_W-1:0] G_UNREACHED = 7'd127;

  localparam logic [1:0] ST_NONE   = 2'd0;
  localparam logic [1:0] ST_OPEN   = 2'd1;
  localparam logic [1:0] ST_CLOSED = 2'd2;

  localparam logic [2:0] OL_NOP    = 3'd0;
  localparam logic [2:0] OL_CLEAR  = 3'd1;
  localparam logic [2:0] OL_POP    = 3'd2;
  localparam logic [2:0] OL_INSERT = 3'd3;
  localparam logic [2:0] OL_UPDATE = 3'd4;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [G_W-1:0]     f;
  } ol_entry_t;

  typedef struct packed {
    logic [2:0] op;
    ol_entry_t  ent;
  } ol_cmd_t;

  typedef struct packed {
    logic [G_W-1:0]     g;
    logic [G_W-1:0]     f;
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
    logic               pv;
    logic [1:0]         st;
  } cell_rec_t;

  localparam cell_rec_t REC_RESET = '{g: G_UNREACHED, f: '0, px: '0, py: '0,
                                      pv: 1'b0, st: ST_NONE};

  function automatic logic [COORD_W-1:0] absd(input logic [COORD_W-1:0] a,
                                              input logic [COORD_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

// ===== src/grid_astar_path_search.sv =====
// Grid A* path search, four neighbours, unit cost, Manhattan estimate.
// Input words are taken on start && !busy. in_func = 0 stores one map cell
// (no result). in_func = 1 runs a search from in_start_* to
// in_goal_* over the map_width x map_height grid set on the cfg port.
// Results appear on out_* for one cycle each, flagged by out_valid, goal
// first and walking back to (not including) the start; out_last marks the
// final word. Empty path or failure gives a single word with has_cell = 0.
// A search sets up, then for each expanded cell pops it, reads and closes its
// record, and visits each neighbour inside the grid with a read and an update
// step, skipping each one outside it; the pace is bounded by the cell-record
// memory's single read port. The path then streams at one word per cycle.
// Start outside the grid answers without a search.
// The open list is a chain of cells, one entry each, all shifting together.
// Reset blocks every map cell and sets the grid to 8 x 8; the cfg port is
// always ready. The receiver cannot stall, so no result is ever held.
module grid_astar_path_search #(
  parameter int MAX_WIDTH  = aspf_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = aspf_pkg::DEF_MAX_HEIGHT
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic                             in_func,
  input  logic [aspf_pkg::COORD_W-1:0]     in_cell_x,
  input  logic [aspf_pkg::COORD_W-1:0]     in_cell_y,
  input  logic                             in_passable,
  input  logic [aspf_pkg::COORD_W-1:0]     in_start_x,
  input  logic [aspf_pkg::COORD_W-1:0]     in_start_y,
  input  logic [aspf_pkg::COORD_W-1:0]     in_goal_x,
  input  logic [aspf_pkg::COORD_W-1:0]     in_goal_y,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [aspf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [aspf_pkg::DIM_W-1:0]       cfg_data,
  output logic                             out_valid,
  output logic [aspf_pkg::COORD_W-1:0]     out_path_x,
  output logic [aspf_pkg::COORD_W-1:0]     out_path_y,
  output logic                             out_has_cell,
  output logic                             out_found,
  output logic                             out_last
);
  import aspf_pkg::*;

  localparam int NCELLS = MAX_WIDTH * MAX_HEIGHT;
  localparam int IDX_W  = $clog2(NCELLS);
  localparam int CNT_W  = $clog2(NCELLS + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_INIT = 4'd1;
  localparam logic [3:0] S_POP  = 4'd2;
  localparam logic [3:0] S_CUR  = 4'd3;
  localparam logic [3:0] S_NB   = 4'd4;
  localparam logic [3:0] S_NBD  = 4'd5;
  localparam logic [3:0] S_TRC  = 4'd6;
  localparam logic [3:0] S_TRP  = 4'd7;

  logic [3:0]         state_r, state_nxt;
  logic [DIM_W-1:0]   width_r, height_r;
  logic [COORD_W-1:0] goal_x_r, goal_y_r, cur_x_r, cur_y_r, nb_x_r, nb_y_r;
  logic [COORD_W-1:0] goal_x_nxt, goal_y_nxt, cur_x_nxt, cur_y_nxt;
  logic [COORD_W-1:0] nb_x_nxt, nb_y_nxt;
  logic [G_W-1:0]     newg_r, newg_nxt;
  logic [1:0]         dir_r, dir_nxt;
  logic [CNT_W-1:0]   pops_r, pops_nxt, k_r, k_nxt;
  logic [NCELLS-1:0]  touched_r, pm_valid_r;
  logic               touch_clr;

  logic               out_valid_r, out_valid_nxt;
  logic [COORD_W-1:0] out_x_r, out_x_nxt, out_y_r, out_y_nxt;
  logic               out_has_r, out_has_nxt, out_found_r, out_found_nxt;
  logic               out_last_r, out_last_nxt;

  cell_rec_t          rec_mem [NCELLS];
  logic               pass_mem [NCELLS];
  cell_rec_t          rec_rd_r, rec_cur, rec_wdata, rec_n;
  logic               pass_rd_r, touched_rd_r, pm_rd_r, pass_cur;
  logic               rec_we, pass_we, pass_wdata;
  logic [IDX_W-1:0]   rec_waddr, pass_waddr, rd_addr;

  ol_cmd_t            ol_cmd;
  ol_entry_t          ol_head;
  logic               ol_head_valid;
  logic [CNT_W-1:0]   ol_count;

  logic [DIM_W-1:0]   w_eff, h_eff, nx4, ny4;
  logic               nb_ok, upd;
  logic [DIM_W-1:0]   h_start, h_nb;
  logic [G_W-1:0]     f_new;

  function automatic logic [IDX_W-1:0] idx_of(input logic [COORD_W-1:0] x,
                                              input logic [COORD_W-1:0] y);
    return IDX_W'(int'(y) * MAX_WIDTH + int'(x));
  endfunction

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  assign w_eff = (width_r > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : width_r;
  assign h_eff = (height_r > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : height_r;

  assign rec_cur  = touched_rd_r ? rec_rd_r : REC_RESET;
  assign pass_cur = pm_rd_r & pass_rd_r;

  assign h_start = DIM_W'(absd(goal_x_r, cur_x_r)) + DIM_W'(absd(goal_y_r, cur_y_r));
  assign h_nb    = DIM_W'(absd(goal_x_r, nb_x_r)) + DIM_W'(absd(goal_y_r, nb_y_r));
  assign f_new   = newg_r + G_W'(h_nb);

  always_comb begin
    nx4   = {1'b0, cur_x_r};
    ny4   = {1'b0, cur_y_r};
    nb_ok = 1'b1;
    unique case (dir_r)
      2'd0: begin nx4 = {1'b0, cur_x_r} - 1'b1; nb_ok = (cur_x_r != '0); end
      2'd1: begin ny4 = {1'b0, cur_y_r} - 1'b1; nb_ok = (cur_y_r != '0); end
      2'd2: ny4 = {1'b0, cur_y_r} + 1'b1;
      2'd3: nx4 = {1'b0, cur_x_r} + 1'b1;
      default: nb_ok = 1'b0;
    endcase
    nb_ok = nb_ok && (nx4 < w_eff) && (ny4 < h_eff);
  end

  always_comb begin
    state_nxt     = state_r;
    goal_x_nxt    = goal_x_r;
    goal_y_nxt    = goal_y_r;
    cur_x_nxt     = cur_x_r;
    cur_y_nxt     = cur_y_r;
    nb_x_nxt      = nb_x_r;
    nb_y_nxt      = nb_y_r;
    newg_nxt      = newg_r;
    dir_nxt       = dir_r;
    pops_nxt      = pops_r;
    k_nxt         = k_r;
    touch_clr     = 1'b0;
    out_valid_nxt = 1'b0;
    out_x_nxt     = '0;
    out_y_nxt     = '0;
    out_has_nxt   = 1'b0;
    out_found_nxt = 1'b0;
    out_last_nxt  = 1'b0;
    rec_we        = 1'b0;
    rec_waddr     = idx_of(nb_x_r, nb_y_r);
    rec_wdata     = rec_cur;
    rec_n         = rec_cur;
    upd           = 1'b0;
    pass_we       = 1'b0;
    pass_waddr    = idx_of(in_cell_x, in_cell_y);
    pass_wdata    = in_passable;
    rd_addr       = idx_of(cur_x_r, cur_y_r);
    ol_cmd        = '{op: OL_NOP, ent: '0};

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (!in_func) begin
            pass_we = ({1'b0, in_cell_x} < DIM_W'(MAX_WIDTH)) &&
                      ({1'b0, in_cell_y} < DIM_W'(MAX_HEIGHT));
          end else if ({1'b0, in_start_x} >= w_eff || {1'b0, in_start_y} >= h_eff) begin
            out_valid_nxt = 1'b1;
            out_last_nxt  = 1'b1;
          end else begin
            goal_x_nxt = in_goal_x;
            goal_y_nxt = in_goal_y;
            cur_x_nxt  = in_start_x;
            cur_y_nxt  = in_start_y;
            touch_clr  = 1'b1;
            ol_cmd.op  = OL_CLEAR;
            state_nxt  = S_INIT;
          end
        end
      end
      S_INIT: begin
        rec_we    = 1'b1;
        rec_waddr = idx_of(cur_x_r, cur_y_r);
        rec_wdata = '{g: '0, f: G_W'(h_start), px: '0, py: '0, pv: 1'b0, st: ST_NONE};
        ol_cmd    = '{op: OL_INSERT, ent: '{x: cur_x_r, y: cur_y_r, f: G_W'(h_start)}};
        pops_nxt  = '0;
        state_nxt = S_POP;
      end
      S_POP: begin
        if (!ol_head_valid || pops_r == CNT_W'(NCELLS)) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          ol_cmd.op = OL_POP;
          cur_x_nxt = ol_head.x;
          cur_y_nxt = ol_head.y;
          pops_nxt  = pops_r + 1'b1;
          rd_addr   = idx_of(ol_head.x, ol_head.y);
          k_nxt     = '0;
          state_nxt = (ol_head.x == goal_x_r && ol_head.y == goal_y_r) ? S_TRC : S_CUR;
        end
      end
      S_CUR: begin
        rec_we       = 1'b1;
        rec_waddr    = idx_of(cur_x_r, cur_y_r);
        rec_wdata.st = ST_CLOSED;
        newg_nxt     = rec_cur.g + 1'b1;
        dir_nxt      = '0;
        state_nxt    = S_NB;
      end
      S_NB: begin
        if (nb_ok) begin
          nb_x_nxt  = nx4[COORD_W-1:0];
          nb_y_nxt  = ny4[COORD_W-1:0];
          rd_addr   = idx_of(nx4[COORD_W-1:0], ny4[COORD_W-1:0]);
          state_nxt = S_NBD;
        end else begin
          dir_nxt   = dir_r + 1'b1;
          state_nxt = (dir_r == 2'd3) ? S_POP : S_NB;
        end
      end
      S_NBD: begin
        if (pass_cur && rec_cur.st != ST_CLOSED) begin
          upd = newg_r < rec_cur.g;
          if (upd) begin
            rec_n.g  = newg_r;
            rec_n.f  = f_new;
            rec_n.px = cur_x_r;
            rec_n.py = cur_y_r;
            rec_n.pv = 1'b1;
          end
          if (rec_cur.st == ST_OPEN) begin
            if (upd) begin
              ol_cmd = '{op: OL_UPDATE, ent: '{x: nb_x_r, y: nb_y_r, f: f_new}};
            end
          end else begin
            if (ol_count != CNT_W'(NCELLS)) begin
              ol_cmd = '{op: OL_INSERT, ent: '{x: nb_x_r, y: nb_y_r, f: rec_n.f}};
            end
            rec_n.st = ST_OPEN;
          end
          rec_we    = 1'b1;
          rec_wdata = rec_n;
        end
        dir_nxt   = dir_r + 1'b1;
        state_nxt = (dir_r == 2'd3) ? S_POP : S_NB;
      end
      S_TRC: begin
        if (!rec_cur.pv) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = 1'b1;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          rd_addr   = idx_of(rec_cur.px, rec_cur.py);
          cur_x_nxt = rec_cur.px;
          cur_y_nxt = rec_cur.py;
          nb_x_nxt  = cur_x_r;
          nb_y_nxt  = cur_y_r;
          state_nxt = S_TRP;
        end
      end
      S_TRP: begin
        // nb_* holds the cell on show, rec_cur its parent's record
        out_valid_nxt = 1'b1;
        out_x_nxt     = nb_x_r;
        out_y_nxt     = nb_y_r;
        out_has_nxt   = 1'b1;
        out_found_nxt = 1'b1;
        out_last_nxt  = !rec_cur.pv || (k_r == CNT_W'(NCELLS - 1));
        k_nxt         = k_r + 1'b1;
        rd_addr       = idx_of(rec_cur.px, rec_cur.py);
        nb_x_nxt      = cur_x_r;
        nb_y_nxt      = cur_y_r;
        cur_x_nxt     = rec_cur.px;
        cur_y_nxt     = rec_cur.py;
        if (out_last_nxt) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rec_we) begin
      rec_mem[rec_waddr] <= rec_wdata;
    end
    if (pass_we) begin
      pass_mem[pass_waddr] <= pass_wdata;
    end
    rec_rd_r     <= rec_mem[rd_addr];
    pass_rd_r    <= pass_mem[rd_addr];
    touched_rd_r <= touched_r[rd_addr];
    pm_rd_r      <= pm_valid_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      width_r     <= DIM_W'(8);
      height_r    <= DIM_W'(8);
      touched_r   <= '0;
      pm_valid_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_REG_WIDTH) width_r <= cfg_data;
        if (cfg_index == CFG_REG_HEIGHT) height_r <= cfg_data;
      end
      if (touch_clr) begin
        touched_r <= '0;
      end else if (rec_we) begin
        touched_r[rec_waddr] <= 1'b1;
      end
      if (pass_we) begin
        pm_valid_r[pass_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    goal_x_r    <= goal_x_nxt;
    goal_y_r    <= goal_y_nxt;
    cur_x_r     <= cur_x_nxt;
    cur_y_r     <= cur_y_nxt;
    nb_x_r      <= nb_x_nxt;
    nb_y_r      <= nb_y_nxt;
    newg_r      <= newg_nxt;
    dir_r       <= dir_nxt;
    pops_r      <= pops_nxt;
    k_r         <= k_nxt;
    out_x_r     <= out_x_nxt;
    out_y_r     <= out_y_nxt;
    out_has_r   <= out_has_nxt;
    out_found_r <= out_found_nxt;
    out_last_r  <= out_last_nxt;
  end

  aspf_open_list #(.DEPTH(NCELLS)) u_open (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (ol_cmd),
    .head       (ol_head),
    .head_valid (ol_head_valid),
    .count      (ol_count)
  );

  assign out_valid    = out_valid_r;
  assign out_path_x   = out_x_r;
  assign out_path_y   = out_y_r;
  assign out_has_cell = out_has_r;
  assign out_found    = out_found_r;
  assign out_last     = out_last_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> !busy)
    else $error("final word while search still running");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_has_cell) |-> out_last)
    else $error("empty word not marked last");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_has_cell) |-> out_found)
    else $error("path cell without goal reached");

  assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_func) |=> (busy || out_valid))
    else $error("search word dropped");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> busy)
    else $error("path stream stopped early");

endmodule

// ===== src/aspf_cell.sv =====
module aspf_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  aspf_pkg::ol_cmd_t   cmd,
  input  logic                above,
  input  logic                prev_valid,
  input  aspf_pkg::ol_entry_t prev_ent,
  input  logic                next_valid,
  input  aspf_pkg::ol_entry_t next_ent,
  output logic                valid,
  output aspf_pkg::ol_entry_t ent,
  output logic                mark
);
  import aspf_pkg::*;

  logic      valid_r, valid_nxt;
  ol_entry_t ent_r, ent_nxt;

  assign valid = valid_r;
  assign ent   = ent_r;
  // insertion point: first entry from the head whose F is at least the new F, or the first empty cell
  assign mark  = !valid_r || (ent_r.f >= cmd.ent.f);

  always_comb begin
    valid_nxt = valid_r;
    ent_nxt   = ent_r;
    unique case (cmd.op)
      OL_CLEAR: begin
        valid_nxt = 1'b0;
      end
      OL_POP: begin
        valid_nxt = next_valid;
        ent_nxt   = next_ent;
      end
      OL_INSERT: begin
        if (above) begin
          valid_nxt = prev_valid;
          ent_nxt   = prev_ent;
        end else if (mark) begin
          valid_nxt = 1'b1;
          ent_nxt   = cmd.ent;
        end
      end
      OL_UPDATE: begin
        if (valid_r && ent_r.x == cmd.ent.x && ent_r.y == cmd.ent.y) begin
          ent_nxt.f = cmd.ent.f;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

endmodule

// ===== src/aspf_open_list.sv =====
module aspf_open_list #(
  parameter int DEPTH = aspf_pkg::DEF_MAX_WIDTH * aspf_pkg::DEF_MAX_HEIGHT
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  aspf_pkg::ol_cmd_t            cmd,
  output aspf_pkg::ol_entry_t          head,
  output logic                         head_valid,
  output logic [$clog2(DEPTH+1)-1:0]   count
);
  import aspf_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DEPTH-1:0] valid;
  logic [DEPTH-1:0] mark;
  ol_entry_t        ents [DEPTH];
  logic [CNT_W-1:0] count_r, count_nxt;

  for (genvar j = 0; j < DEPTH; j++) begin : g_cell
    logic      pv, nv, ab;
    ol_entry_t pe, ne;
    if (j == 0) begin : g_first
      assign pv = 1'b0;
      assign pe = '0;
      assign ab = 1'b0;
    end else begin : g_mid
      assign pv = valid[j-1];
      assign pe = ents[j-1];
      assign ab = |mark[j-1:0];
    end
    if (j == DEPTH - 1) begin : g_last
      assign nv = 1'b0;
      assign ne = '0;
    end else begin : g_inner
      assign nv = valid[j+1];
      assign ne = ents[j+1];
    end
    aspf_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .above      (ab),
      .prev_valid (pv),
      .prev_ent   (pe),
      .next_valid (nv),
      .next_ent   (ne),
      .valid      (valid[j]),
      .ent        (ents[j]),
      .mark       (mark[j])
    );
  end

  assign head       = ents[0];
  assign head_valid = valid[0];
  assign count      = count_r;

  always_comb begin
    count_nxt = count_r;
    unique case (cmd.op)
      OL_CLEAR:  count_nxt = '0;
      OL_POP:    if (count_r != '0) count_nxt = count_r - 1'b1;
      OL_INSERT: if (count_r != CNT_W'(DEPTH)) count_nxt = count_r + 1'b1;
      default:   count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("open list count overflow");

  assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) == !valid[0])
    else $error("open list head disagrees with count");

  assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OL_INSERT && count_r != CNT_W'(DEPTH)) |=> valid[0])
    else $error("insert left the list empty");

endmodule
